// File: design/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared widths, constants and types of the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // number of cordic iterations, valid range 8..24
  localparam int CORDIC_STEPS = 16;
  localparam int NSTEPS = (CORDIC_STEPS < 8) ? 8 : ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS);

  localparam int FW     = 16;  // width of every input and output field
  localparam int NUM_OUT = 9;
  localparam int XW     = 33;  // cordic x / y, Q30 with headroom
  localparam int ZW     = 34;  // cordic angle, Q30
  localparam int TW     = 34;  // 1 - cos, Q30

  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [TW-1:0] ONE_Q30     = 34'sd1073741824;

  // cordic stage result handed to the matrix stages
  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [FW-1:0]   ax;
    logic signed [FW-1:0]   ay;
    logic signed [FW-1:0]   az;
  } rot_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    case (idx)
      0:  atan_q30 = 34'sd843314857;
      1:  atan_q30 = 34'sd497837829;
      2:  atan_q30 = 34'sd263043837;
      3:  atan_q30 = 34'sd133525159;
      4:  atan_q30 = 34'sd67021687;
      5:  atan_q30 = 34'sd33543516;
      6:  atan_q30 = 34'sd16775851;
      7:  atan_q30 = 34'sd8388437;
      8:  atan_q30 = 34'sd4194283;
      9:  atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048576;
      11: atan_q30 = 34'sd524288;
      12: atan_q30 = 34'sd262144;
      13: atan_q30 = 34'sd131072;
      14: atan_q30 = 34'sd65536;
      15: atan_q30 = 34'sd32768;
      16: atan_q30 = 34'sd16384;
      17: atan_q30 = 34'sd8192;
      18: atan_q30 = 34'sd4096;
      19: atan_q30 = 34'sd2048;
      20: atan_q30 = 34'sd1024;
      21: atan_q30 = 34'sd512;
      22: atan_q30 = 34'sd256;
      23: atan_q30 = 34'sd128;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: design/axis_angle_rotation_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// pipeline: an input transfer passes one fold stage, one stage per cordic
// iteration and four matrix stages before m_tvalid rises
// throughput: one matrix per cycle; a stall on m_tready freezes the whole pipeline
// reset: synchronous rst clears every stage valid bit; data registers are not reset
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// 3x3 rotation matrix from a unit axis and an angle by the Rodrigues formula.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
  input  wire logic [63:0]   s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each from bit 0 up
  output logic [143:0]       m_tdata
);

  logic           adv;
  aarm_pkg::rot_t rot;

  // the pipeline moves whenever the output register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  aarm_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .axis_x   (s_tdata[15:0]),
    .axis_y   (s_tdata[31:16]),
    .axis_z   (s_tdata[47:32]),
    .angle    (s_tdata[63:48]),
    .rot      (rot)
  );

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rot       (rot),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

// File: design/aarm_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_cordic
// Angle fold into -pi/2..pi/2 followed by a rotation-mode cordic, one
// register stage per iteration. The axis travels alongside.
// ----------------------------------------------------------------------------
module aarm_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic signed [aarm_pkg::FW-1:0] axis_x,
  input  wire logic signed [aarm_pkg::FW-1:0] axis_y,
  input  wire logic signed [aarm_pkg::FW-1:0] axis_z,
  input  wire logic signed [aarm_pkg::FW-1:0] angle,
  output aarm_pkg::rot_t                     rot
);

  localparam int N = aarm_pkg::NSTEPS;

  logic                                valid_q [N+1];
  logic                                flip_q  [N+1];
  logic signed [aarm_pkg::XW-1:0]      x_q     [N+1];
  logic signed [aarm_pkg::XW-1:0]      y_q     [N+1];
  logic signed [aarm_pkg::ZW-1:0]      z_q     [N+1];
  logic signed [aarm_pkg::FW-1:0]      ax_q    [N+1];
  logic signed [aarm_pkg::FW-1:0]      ay_q    [N+1];
  logic signed [aarm_pkg::FW-1:0]      az_q    [N+1];

  logic signed [aarm_pkg::ZW-1:0] z_in;
  logic signed [aarm_pkg::ZW-1:0] z_fold;
  logic                           flip_in;

  // Q3.13 to Q30
  assign z_in = {angle[aarm_pkg::FW-1], angle, 17'd0};

  always_comb begin
    if (z_in > aarm_pkg::HALF_PI_Q30) begin
      z_fold  = z_in - aarm_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (z_in < -aarm_pkg::HALF_PI_Q30) begin
      z_fold  = z_in + aarm_pkg::PI_Q30;
      flip_in = 1'b1;
    end else begin
      z_fold  = z_in;
      flip_in = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flip_q[0] <= flip_in;
      x_q[0]    <= aarm_pkg::GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      ax_q[0]   <= axis_x;
      ay_q[0]   <= axis_y;
      az_q[0]   <= axis_z;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (adv) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_q[k][aarm_pkg::ZW-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - aarm_pkg::atan_q30(k);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + aarm_pkg::atan_q30(k);
        end
        flip_q[k+1] <= flip_q[k];
        ax_q[k+1]   <= ax_q[k];
        ay_q[k+1]   <= ay_q[k];
        az_q[k+1]   <= az_q[k];
      end
    end
  end

  assign rot.valid = valid_q[N];
  assign rot.flip  = flip_q[N];
  assign rot.x     = x_q[N];
  assign rot.y     = y_q[N];
  assign rot.ax    = ax_q[N];
  assign rot.ay    = ay_q[N];
  assign rot.az    = az_q[N];

endmodule
`default_nettype wire

// File: design/aarm_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues matrix from cos, sin and axis: axis products, scaling by
// 1 - cos and sin, nine Q58 sums, then rounding and saturation to Q2.14.
// ----------------------------------------------------------------------------
module aarm_matrix (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       adv,
  input  aarm_pkg::rot_t                                  rot,
  output logic                                            out_valid,
  output logic [aarm_pkg::NUM_OUT*aarm_pkg::FW-1:0]       out_data
);

  localparam int XW = aarm_pkg::XW;
  localparam int TW = aarm_pkg::TW;
  localparam int FW = aarm_pkg::FW;
  localparam int PW = 2 * FW;
  localparam int SW = XW + FW - 1;
  localparam int AW = 64;
  localparam int NP = 6;

  // axis product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;

  localparam logic signed [AW-1:0] ROUND = 64'sd1 <<< 43;

  function automatic logic [FW-1:0] sat(input logic signed [AW-1:0] acc);
    logic signed [AW-45:0] r;
    r = acc[AW-1:44];
    if (r > 20'sd32767) begin
      sat = 16'h7fff;
    end else if (r < -20'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = r[FW-1:0];
    end
  endfunction

  // stage a: sign fold, 1 - cos, axis products
  logic signed [FW-1:0] ax_w, ay_w, az_w;
  logic signed [XW-1:0] c_w, s_w;
  logic signed [PW-1:0] p_w [NP];

  assign ax_w = rot.ax;
  assign ay_w = rot.ay;
  assign az_w = rot.az;
  assign c_w  = rot.flip ? -rot.x : rot.x;
  assign s_w  = rot.flip ? -rot.y : rot.y;

  assign p_w[P_XX] = ax_w * ax_w;
  assign p_w[P_YY] = ay_w * ay_w;
  assign p_w[P_ZZ] = az_w * az_w;
  assign p_w[P_XY] = ax_w * ay_w;
  assign p_w[P_XZ] = ax_w * az_w;
  assign p_w[P_YZ] = ay_w * az_w;

  logic                 valid_a;
  logic signed [XW-1:0] c_a, s_a;
  logic signed [TW-1:0] t_a;
  logic signed [PW-1:0] p_a [NP];
  logic signed [FW-1:0] ax_a, ay_a, az_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (adv) begin
      valid_a <= rot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_a  <= c_w;
      s_a  <= s_w;
      t_a  <= aarm_pkg::ONE_Q30 - TW'(c_w);
      ax_a <= ax_w;
      ay_a <= ay_w;
      az_a <= az_w;
      for (int j = 0; j < NP; j++) begin
        p_a[j] <= p_w[j];
      end
    end
  end

  // stage b: wide products
  logic                 valid_b;
  logic signed [AW-1:0] tp_b [NP];
  logic signed [AW-1:0] cc_b;
  logic signed [SW-1:0] sx_b, sy_b, sz_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (adv) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NP; j++) begin
        tp_b[j] <= t_a * p_a[j];
      end
      cc_b <= AW'(c_a) <<< 28;
      sx_b <= s_a * ax_a;
      sy_b <= s_a * ay_a;
      sz_b <= s_a * az_a;
    end
  end

  // stage c: Q58 sums with the rounding half folded in
  logic signed [AW-1:0] sx_w, sy_w, sz_w;
  assign sx_w = AW'(sx_b) <<< 14;
  assign sy_w = AW'(sy_b) <<< 14;
  assign sz_w = AW'(sz_b) <<< 14;

  logic                 valid_c;
  logic signed [AW-1:0] acc_c [aarm_pkg::NUM_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else if (adv) begin
      valid_c <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_c[0] <= cc_b + tp_b[P_XX] + ROUND;
      acc_c[1] <= tp_b[P_XY] - sz_w + ROUND;
      acc_c[2] <= tp_b[P_XZ] + sy_w + ROUND;
      acc_c[3] <= tp_b[P_XY] + sz_w + ROUND;
      acc_c[4] <= cc_b + tp_b[P_YY] + ROUND;
      acc_c[5] <= tp_b[P_YZ] - sx_w + ROUND;
      acc_c[6] <= tp_b[P_XZ] - sy_w + ROUND;
      acc_c[7] <= tp_b[P_YZ] + sx_w + ROUND;
      acc_c[8] <= cc_b + tp_b[P_ZZ] + ROUND;
    end
  end

  // stage d: shift, saturate, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < aarm_pkg::NUM_OUT; j++) begin
        out_data[j*FW +: FW] <= sat(acc_c[j]);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/aarm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks of the rotation matrix pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [143:0] m_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // input side stalls exactly when the output register is blocked
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  // no input transfer while the output is stalled
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
    else $error("input taken during output stall");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the axis-angle rotation matrix pipeline: an
// internal bit-exact model of the fold, cordic and rodrigues arithmetic
// predicts every matrix, and each output transfer is compared entry by entry
// while both stream sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb;

  // clamped cordic iteration count and pipeline depth
  localparam int STEPS = (aarm_pkg::CORDIC_STEPS < 8) ? 8 :
                         ((aarm_pkg::CORDIC_STEPS > 24) ? 24 : aarm_pkg::CORDIC_STEPS);
  localparam int PIPE_DEPTH = STEPS + 4;

  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1686629713;
  localparam longint HALF_TURN = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int MAX_REPORTS = 10;

  // atan(2^-i) in Q30
  localparam longint ATAN_TAB [0:23] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  // one input transfer, axis_x in the lowest bits
  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_x;
  } axis_angle_t;

  // nine Q2.14 entries, m00 in the lowest bits, row-major
  typedef logic [143:0] rot3_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  rot3_t matrix_q[$];

  string ENTRY_NAME [0:8] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  axis_angle_rotation_matrix u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // round the Q58 sum to Q2.14 and saturate
  function automatic logic [15:0] round_sat(longint acc);
    longint r;
    r = (acc + (longint'(1) << 43)) >>> 44;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic rot3_t rodrigues_matrix(axis_angle_t it);
    longint ax, ay, az, x, y, z, dx, dy, c, s, t, cc, sx, sy, sz;
    bit flip;
    rot3_t m;
    ax = it.axis_x;
    ay = it.axis_y;
    az = it.axis_z;
    z = longint'(it.angle) * 131072;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    // fold into the cordic convergence range, negate cos and sin afterwards
    if (z > QUARTER_TURN) begin
      z = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE_Q30 - c;
    cc = c * (longint'(1) << 28);
    sx = ax * s * 16384;
    sy = ay * s * 16384;
    sz = az * s * 16384;
    m[15:0]    = round_sat(cc + t * (ax * ax));
    m[31:16]   = round_sat(t * (ax * ay) - sz);
    m[47:32]   = round_sat(t * (ax * az) + sy);
    m[63:48]   = round_sat(t * (ax * ay) + sz);
    m[79:64]   = round_sat(cc + t * (ay * ay));
    m[95:80]   = round_sat(t * (ay * az) - sx);
    m[111:96]  = round_sat(t * (ax * az) - sy);
    m[127:112] = round_sat(t * (ay * az) + sx);
    m[143:128] = round_sat(cc + t * (az * az));
    return m;
  endfunction

  function automatic axis_angle_t aa(int ax, int ay, int az, int ang);
    axis_angle_t it;
    it.axis_x = ax[15:0];
    it.axis_y = ay[15:0];
    it.axis_z = az[15:0];
    it.angle = ang[15:0];
    return it;
  endfunction

  // random axis of unit length, angle within minus pi to pi
  function automatic axis_angle_t unit_axis_item();
    real vx, vy, vz, len;
    do begin
      vx = $itor($urandom_range(32768)) - 16384.0;
      vy = $itor($urandom_range(32768)) - 16384.0;
      vz = $itor($urandom_range(32768)) - 16384.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz);
    end while (len < 1000.0 || len > 16384.0);
    return aa($rtoi(vx * 16384.0 / len), $rtoi(vy * 16384.0 / len),
              $rtoi(vz * 16384.0 / len), int'($urandom_range(51472)) - 25736);
  endfunction

  // predict on every input transfer
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      matrix_q.push_back(rodrigues_matrix(axis_angle_t'(s_tdata)));
  end

  // compare every output transfer with the oldest prediction
  always @(posedge clk) begin
    rot3_t want;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      if (matrix_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected output transfer %h", $time, m_tdata);
      end else begin
        want = matrix_q.pop_front();
        bad = 1'b0;
        for (int k = 0; k < 9; k++) begin
          if (m_tdata[16*k +: 16] !== want[16*k +: 16]) begin
            bad = 1'b1;
            if (n_errors < MAX_REPORTS)
              $display("[%0t] matrix %0d %s: expected %0d, got %0d", $time, n_checked,
                       ENTRY_NAME[k], $signed(want[16*k +: 16]),
                       $signed(m_tdata[16*k +: 16]));
          end
        end
        if (bad) n_errors++;
      end
      n_checked++;
    end
  end

  // sink side ready pattern
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(axis_angle_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  // hold off the source until every predicted matrix has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (matrix_q.size() != 0);
  endtask

  // mostly unit axes, some coordinate axes, some raw 16 bit noise
  task automatic random_burst(int count);
    int pick;
    int sgn;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      sgn = $urandom_range(1) ? 16384 : -16384;
      if (pick < 70)
        send_item(unit_axis_item());
      else if (pick < 85) begin
        case ($urandom_range(2))
          0: send_item(aa(sgn, 0, 0, int'($urandom_range(51472)) - 25736));
          1: send_item(aa(0, sgn, 0, int'($urandom_range(51472)) - 25736));
          default: send_item(aa(0, 0, sgn, int'($urandom_range(51472)) - 25736));
        endcase
      end else
        send_item(axis_angle_t'({$urandom, $urandom}));
    end
    drain();
  endtask

  task automatic test_directed_cases();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_item(aa(16384, 0, 0, 0));
    send_item(aa(16384, 0, 0, 25736));         // plus pi
    send_item(aa(16384, 0, 0, -25736));        // minus pi
    send_item(aa(0, 16384, 0, 12867));         // just below pi/2, no fold
    send_item(aa(0, 16384, 0, 12868));         // just above pi/2, folded
    send_item(aa(0, 0, 16384, -12867));
    send_item(aa(0, 0, 16384, -12868));
    send_item(aa(-16384, 0, 0, 6434));
    send_item(aa(0, -16384, 0, -6434));
    send_item(aa(0, 0, -16384, 1));
    send_item(aa(9459, 9459, 9459, 17157));    // diagonal axis, 120 degrees
    send_item(aa(16384, 0, 0, 32767));         // angle beyond pi
    send_item(aa(0, 16384, 0, -32768));        // angle beyond minus pi
    send_item(aa(32767, 32767, 32767, 25736)); // long axis, saturating entries
    send_item(aa(-32768, -32768, -32768, -25736));
    send_item(aa(-32768, 32767, -32768, 12868));
    send_item(aa(0, 0, 0, 10000));             // zero axis
    send_item(aa(16384, 16384, 16384, 0));
    send_item(aa(-1, -1, -1, -1));
    send_item(aa(11585, -11585, 0, 20000));
    drain();
  endtask

  task automatic test_steady_stream();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    random_burst(300);
  endtask

  task automatic test_source_gaps();
    src_idle_pct = 48;
    snk_stall_pct = 0;
    random_burst(300);
  endtask

  task automatic test_sink_stalls();
    src_idle_pct = 0;
    snk_stall_pct = 48;
    random_burst(300);
  endtask

  task automatic test_light_idling();
    src_idle_pct = 6;
    snk_stall_pct = 6;
    random_burst(300);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_steady_stream();
    test_source_gaps();
    test_sink_stalls();
    test_light_idling();
    snk_stall_pct = 0;
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (matrix_q.size() != 0) n_errors++;
    $display("%0d axis-angle items sent, %0d matrices checked, %0d bad", n_sent, n_checked,
             n_errors);
    $display("phases: steady stream, source gaps, sink stalls, light idling on both sides");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
design/aarm_pkg.sv
design/aarm_cordic.sv
design/aarm_matrix.sv
design/axis_angle_rotation_matrix.sv
design/aarm_checker.sv
tb/tb.sv
